/* rtl/cdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_SEARCH    = 3'd4,
        OP_CLEAR     = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] removed_value;
        logic                     found;
        logic [POS_W-1:0]         position;
        logic                     now_empty;
        status_t                  status;
    } result_t;

endpackage

`default_nettype wire

/* rtl/cdq_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module cdq_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    localparam int IDX_W      = $clog2(DEPTH)
) (
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [IDX_W-1:0]       wr_addr,
    input  wire logic [VALUE_WIDTH-1:0] wr_data,
    input  wire logic [IDX_W-1:0]       rd_addr,
    output logic      [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/cdq_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module cdq_engine #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cdq_pkg::OP_W-1:0]      op,
    input  wire logic [cdq_pkg::WORD_W-1:0]    value,
    output logic                               idle,
    output logic                               res_valid,
    output cdq_pkg::result_t                   res,
    input  wire logic                          res_take
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_READ = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [cdq_pkg::OP_W-1:0] op_reg, op_next;
    logic [VALUE_WIDTH-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]         scan_slot_reg, scan_slot_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [cdq_pkg::WORD_W-1:0] removed_reg, removed_next;
    logic                     found_reg, found_next;
    cdq_pkg::status_t         status_reg, status_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic [VALUE_WIDTH-1:0]   rd_data;
    logic                     full;
    logic                     empty;
    logic                     last_pos;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH))
        begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(s);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] slot);
        return (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    cdq_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign last_pos = (CNT_W'(pos_reg) == count_reg - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        scan_slot_next = scan_slot_reg;
        pos_next       = pos_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        rd_addr        = scan_slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    key_next   = VALUE_WIDTH'($unsigned(value));
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                removed_next = '0;
                found_next   = 1'b0;
                pos_next     = '0;
                status_next  = cdq_pkg::ST_OK;
                state_next   = S_DONE;
                case (op_reg)
                    cdq_pkg::OP_INS_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = cdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? IDX_W'(DEPTH - 1)
                                                          : head_reg - 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = head_next;
                            count_next = count_reg + 1'b1;
                        end
                    end

                    cdq_pkg::OP_INS_BACK:
                    begin
                        if (full)
                        begin
                            status_next = cdq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = wrap_add(head_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end

                    cdq_pkg::OP_REM_FRONT:
                    begin
                        if (empty)
                        begin
                            status_next = cdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            head_next  = wrap_inc(head_reg);
                            count_next = count_reg - 1'b1;
                            state_next = S_READ;
                        end
                    end

                    cdq_pkg::OP_REM_BACK:
                    begin
                        if (empty)
                        begin
                            status_next = cdq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = wrap_add(head_reg, count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = S_READ;
                        end
                    end

                    cdq_pkg::OP_SEARCH:
                    begin
                        if (!empty)
                        begin
                            rd_addr        = head_reg;
                            scan_slot_next = wrap_inc(head_reg);
                            state_next     = S_SCAN;
                        end
                    end

                    cdq_pkg::OP_CLEAR:
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_READ:
            begin
                // Values narrower than the port come back sign-extended.
                removed_next = cdq_pkg::WORD_W'($signed(rd_data));
                state_next   = S_DONE;
            end

            S_SCAN:
            begin
                // The entry at pos_reg is on rd_data; the next one is fetched meanwhile.
                rd_addr        = scan_slot_reg;
                scan_slot_next = wrap_inc(scan_slot_reg);
                if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (last_pos)
                begin
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        scan_slot_reg <= scan_slot_next;
        pos_reg       <= pos_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.removed_value = removed_reg;
        res.found         = found_reg;
        res.position      = found_reg ? cdq_pkg::POS_W'(pos_reg) : '0;
        res.now_empty     = empty;
        res.status        = status_reg;
    end

endmodule

`default_nettype wire

/* rtl/circular_deque_with_search_top.sv */
//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     op, value
//  output    out        out_valid / out_stall   removed_value, found, position,
//                                               now_empty, status
//
//  Inserts, clear and unknown codes pass through EXEC to a result word,
//  removals add a READ state (one registered store read), and a search scans
//  up to count entries, since one comparator walks the ring one entry a cycle.
//  in_stall stays high from an accept until the result moves to the output register.
//  out_stall holds the output word; the next word may be accepted meanwhile.
//  Reset empties the sequence at once; store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_with_search_top #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [cdq_pkg::OP_W-1:0]             op,
    input  wire logic signed [cdq_pkg::WORD_W-1:0]    value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0]         removed_value,
    output logic                                      found,
    output logic [cdq_pkg::POS_W-1:0]                 position,
    output logic                                      now_empty,
    output logic [cdq_pkg::STATUS_W-1:0]              status
);

    logic             eng_idle;
    logic             res_valid;
    logic             res_take;
    cdq_pkg::result_t res;
    logic             out_valid_reg, out_valid_next;
    cdq_pkg::result_t out_reg;

    cdq_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !in_stall),
        .op        (op),
        .value     (value),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign in_stall = !eng_idle;

    // The output register takes a new word when it is empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = out_reg.removed_value;
    assign found         = out_reg.found;
    assign position      = out_reg.position;
    assign now_empty     = out_reg.now_empty;
    assign status        = out_reg.status;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accepting a word");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> removed_value == '0 && status == cdq_pkg::ST_OK)
        else $error("search hit carries removal data or bad status");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cdq_pkg::ST_EMPTY |-> now_empty && removed_value == '0)
        else $error("removal on empty sequence reported inconsistently");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("nonzero position without a match");
`endif

endmodule

`default_nettype wire
